>>> src/cmv_pkg.sv
// ----------------------------------------------------------------------------
// cmv_pkg
// shared types and constants of the complex matrix-vector mac
// ----------------------------------------------------------------------------
package cmv_pkg;

  localparam int MAX_COLS_DEFAULT = 256;
  localparam int MAX_ROWS_DEFAULT = 1024;

  localparam int PART_W     = 16;
  localparam int COL_W      = 8;
  localparam int ROW_W      = 10;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 2 * PART_W;
  localparam int VEC_W      = 2 * PART_W;
  localparam int VEC_DEPTH  = 256;
  localparam int ROW_LIMIT  = 1024;

  localparam int COLS_CFG_W = 9;
  localparam int ROWS_CFG_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 9'd256;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 11'd1024;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1
  } cmv_cfg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAC  = 1'b1
  } cmv_op_t;

  typedef struct packed {
    cmv_op_t                  op;
    logic [COL_W-1:0]         col;
    logic signed [PART_W-1:0] re;
    logic signed [PART_W-1:0] im;
    logic                     last_col;
  } cmv_entry_t;

  typedef struct packed {
    logic       not_empty;
    logic       full;
    cmv_entry_t head;
  } cmv_qstat_t;

endpackage

>>> src/cmv_if.sv
// ----------------------------------------------------------------------------
// cmv_item_if / cmv_result_if
// valid/ready channels for input items and finished rows
// ----------------------------------------------------------------------------
interface cmv_item_if import cmv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [COL_W-1:0]         col_index;
  logic signed [PART_W-1:0] value_re;
  logic signed [PART_W-1:0] value_im;

  modport source (output valid, operation, col_index, value_re, value_im, input ready);
  modport sink   (input valid, operation, col_index, value_re, value_im, output ready);
endinterface

interface cmv_result_if import cmv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] product_re;
  logic signed [ACC_W-1:0] product_im;
  logic [ROW_W-1:0]        row_number;
  logic                    final_row;

  modport source (output valid, product_re, product_im, row_number, final_row, input ready);
  modport sink   (input valid, product_re, product_im, row_number, final_row, output ready);
endinterface

>>> src/cmv_ram.sv
// ----------------------------------------------------------------------------
// cmv_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/cmv_queue.sv
// ----------------------------------------------------------------------------
// cmv_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module cmv_queue import cmv_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmv_entry_t push_entry,
  input  logic       pop,
  output cmv_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmv_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign stat.not_empty = (count != '0);
  assign stat.full      = (count == CNT_W'(DEPTH));
  assign stat.head      = slots[rd_ptr];

endmodule

>>> src/cmv_front.sv
// ----------------------------------------------------------------------------
// cmv_front
// configuration registers, item intake and last-column classification
// ----------------------------------------------------------------------------
module cmv_front import cmv_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEFAULT,
  parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cmv_item_if.sink              items,
  input  logic                  queue_full,
  output logic                  push,
  output cmv_entry_t            push_entry,
  output logic [ROW_W-1:0]      rows_last
);

  localparam int COL_LIM = (MAX_COLS < VEC_DEPTH) ? MAX_COLS : VEC_DEPTH;
  localparam int ROW_LIM = (MAX_ROWS < ROW_LIMIT) ? MAX_ROWS : ROW_LIMIT;

  logic [COLS_CFG_W-1:0] cols_in_use;
  logic [ROWS_CFG_W-1:0] rows_in_use;
  logic [COL_W-1:0]      cols_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_RESET;
      rows_in_use <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS: cols_in_use <= cfg_data[COLS_CFG_W-1:0];
        CFG_ROWS: rows_in_use <= cfg_data[ROWS_CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  // clamp counts to 1..limit, kept as index of last column / row
  always_comb begin
    if (cols_in_use == '0) begin
      cols_last = '0;
    end else if (cols_in_use > COLS_CFG_W'(COL_LIM)) begin
      cols_last = COL_W'(COL_LIM - 1);
    end else begin
      cols_last = COL_W'(cols_in_use - 1'b1);
    end
    if (rows_in_use == '0) begin
      rows_last = '0;
    end else if (rows_in_use > ROWS_CFG_W'(ROW_LIM)) begin
      rows_last = ROW_W'(ROW_LIM - 1);
    end else begin
      rows_last = ROW_W'(rows_in_use - 1'b1);
    end
  end

  assign items.ready = !queue_full;
  assign push        = items.valid && !queue_full;

  always_comb begin
    push_entry.op       = cmv_op_t'(items.operation);
    push_entry.col      = items.col_index;
    push_entry.re       = items.value_re;
    push_entry.im       = items.value_im;
    push_entry.last_col = (push_entry.op == OP_MAC) && (items.col_index == cols_last);
  end

endmodule

>>> src/cmv_back.sv
// ----------------------------------------------------------------------------
// cmv_back
// vector store, complex multiply pipeline, accumulators and result register
// ----------------------------------------------------------------------------
module cmv_back import cmv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmv_qstat_t       stat,
  output logic             pop,
  input  logic [ROW_W-1:0] rows_last,
  cmv_result_if.source     results
);

  logic                     adv;
  logic                     ram_we;
  logic                     ram_re;
  logic [VEC_W-1:0]         ram_rdata;
  logic signed [PART_W-1:0] x_re;
  logic signed [PART_W-1:0] x_im;

  logic                     s2_valid;
  logic                     s2_last;
  logic signed [PART_W-1:0] s2_are;
  logic signed [PART_W-1:0] s2_aim;

  logic                     s3_valid;
  logic                     s3_last;
  logic signed [PROD_W-1:0] s3_rr;
  logic signed [PROD_W-1:0] s3_ii;
  logic signed [PROD_W-1:0] s3_ri;
  logic signed [PROD_W-1:0] s3_ir;

  logic                     s4_valid;
  logic                     s4_last;
  logic signed [PROD_W:0]   s4_pre;
  logic signed [PROD_W:0]   s4_pim;

  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;
  logic signed [ACC_W-1:0]  acc_re_next;
  logic signed [ACC_W-1:0]  acc_im_next;
  logic [ROW_W-1:0]         row_counter;
  logic                     row_final;

  logic                     res_valid;
  logic signed [ACC_W-1:0]  res_re;
  logic signed [ACC_W-1:0]  res_im;
  logic [ROW_W-1:0]         res_row;
  logic                     res_final;

  // pipeline moves whenever the result register can take a new value
  assign adv    = !res_valid || results.ready;
  assign pop    = adv && stat.not_empty;
  assign ram_we = pop && (stat.head.op == OP_LOAD);
  assign ram_re = pop && (stat.head.op == OP_MAC);

  cmv_ram #(
    .WIDTH (VEC_W),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stat.head.col),
    .wdata ({stat.head.im, stat.head.re}),
    .re    (ram_re),
    .raddr (stat.head.col),
    .rdata (ram_rdata)
  );

  assign x_re = signed'(ram_rdata[PART_W-1:0]);
  assign x_im = signed'(ram_rdata[VEC_W-1:PART_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= ram_re;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last <= stat.head.last_col;
      s2_are  <= stat.head.re;
      s2_aim  <= stat.head.im;
      s3_last <= s2_last;
      s3_rr   <= s2_are * x_re;
      s3_ii   <= s2_aim * x_im;
      s3_ri   <= s2_are * x_im;
      s3_ir   <= s2_aim * x_re;
      s4_last <= s3_last;
      s4_pre  <= (PROD_W+1)'(s3_rr) - (PROD_W+1)'(s3_ii);
      s4_pim  <= (PROD_W+1)'(s3_ri) + (PROD_W+1)'(s3_ir);
    end
  end

  assign acc_re_next = acc_re + ACC_W'(s4_pre);
  assign acc_im_next = acc_im + ACC_W'(s4_pim);
  assign row_final   = (row_counter >= rows_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re      <= '0;
      acc_im      <= '0;
      row_counter <= '0;
      res_valid   <= 1'b0;
    end else if (adv) begin
      res_valid <= s4_valid && s4_last;
      if (s4_valid) begin
        if (s4_last) begin
          acc_re      <= '0;
          acc_im      <= '0;
          row_counter <= row_final ? '0 : row_counter + 1'b1;
        end else begin
          acc_re <= acc_re_next;
          acc_im <= acc_im_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_valid && s4_last) begin
      res_re    <= acc_re_next;
      res_im    <= acc_im_next;
      res_row   <= row_counter;
      res_final <= row_final;
    end
  end

  assign results.valid      = res_valid;
  assign results.product_re = res_re;
  assign results.product_im = res_im;
  assign results.row_number = res_row;
  assign results.final_row  = res_final;

endmodule

>>> src/complex_matrix_vector_mac.sv
// ----------------------------------------------------------------------------
// complex_matrix_vector_mac
// y = A*x over Q1.15 complex values with 48-bit Q18.30 row accumulators
// ----------------------------------------------------------------------------
//
//   channel   role     contents
//   -------   ------   -----------------------------------------------------
//   cfg_*     write    cols_in_use (index 0), rows_in_use (index 1)
//   items     sink     operation, col_index, value_re, value_im
//   results   source   product_re, product_im, row_number, final_row
//
// one item is taken every cycle while the queue is not full; each item needs a single vector ram access
// and the four-stage multiply/accumulate pipeline behind the queue is fully
// pipelined
// a row result reaches the result register through stages s2, s3 and s4 after its last item
// reset is synchronous, clears control state and accumulators, no ram sweep
// a held result freezes the back pipeline; the four-entry queue absorbs
// incoming items until full, then items.ready falls
//
module complex_matrix_vector_mac import cmv_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEFAULT,
  parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cmv_item_if.sink              items,
  cmv_result_if.source          results
);

  // front to queue
  logic             push;
  cmv_entry_t       push_entry;
  // queue to back
  cmv_qstat_t       stat;
  logic             pop;
  // clamped row count, index of the last row
  logic [ROW_W-1:0] rows_last;

  cmv_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .items      (items),
    .queue_full (stat.full),
    .push       (push),
    .push_entry (push_entry),
    .rows_last  (rows_last)
  );

  cmv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .stat       (stat)
  );

  cmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .pop       (pop),
    .rows_last (rows_last),
    .results   (results)
  );

  // after reset nothing is pending and the queue is open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!results.valid && items.ready))
    else $error("not idle after reset");

  // a row past the configured end must close the frame
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.row_number > rows_last)) |-> results.final_row)
    else $error("row beyond last row without final flag");

  // a waiting result holds the whole back end
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |-> !pop)
    else $error("queue popped while result stalled");

  // the back end only takes items that are there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> stat.not_empty)
    else $error("pop from empty queue");

endmodule

>>> dv/complex_matrix_vector_mac_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_matrix_vector_mac_tb
// self-checking bench for the complex matrix-vector mac: a row predictor
// follows every accepted transfer and each finished row is compared field by
// field, across several column/row settings, idle patterns and a long hold-off
// ----------------------------------------------------------------------------
module complex_matrix_vector_mac_tb;
  import cmv_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 8;
  // results pass stages s2, s3, s4 and the result register after their last item; allow margin for the queue
  localparam int DRAIN_CYCLES  = 16;
  // longest wait for outstanding rows before they count as lost
  localparam int SETTLE_LIMIT  = 5000;
  localparam int MAX_PRINTED   = 40;
  localparam int COL_BOUND     = (MAX_COLS_DEFAULT < VEC_DEPTH) ? MAX_COLS_DEFAULT : VEC_DEPTH;
  localparam int ROW_BOUND     = (MAX_ROWS_DEFAULT < ROW_LIMIT) ? MAX_ROWS_DEFAULT : ROW_LIMIT;
  localparam logic signed [PART_W-1:0] PART_MIN = PART_W'(-(2 ** (PART_W - 1)));
  localparam logic signed [PART_W-1:0] PART_MAX = PART_W'(2 ** (PART_W - 1) - 1);
  // indexes beyond the two registers, which must write nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  // idle patterns
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [ACC_W-1:0] re;
    logic [ACC_W-1:0] im;
    logic [ROW_W-1:0] row;
    logic             fin;
  } row_result_t;

  // --------------------------------------------------------------------------
  // row predictor and result store
  // --------------------------------------------------------------------------
  class row_scoreboard;
    logic [VEC_W-1:0]      vec_store [VEC_DEPTH];
    logic [ACC_W-1:0]      acc_re;
    logic [ACC_W-1:0]      acc_im;
    logic [ROW_W-1:0]      row_ctr;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [ROWS_CFG_W-1:0] rows_reg;
    row_result_t           pending_rows [$];
    int                    errors;
    int                    rows_checked;
    int                    loads_seen;
    int                    macs_seen;

    function new();
      foreach (vec_store[i]) vec_store[i] = '0;
      acc_re = '0;
      acc_im = '0;
      row_ctr = '0;
      cols_reg = COLS_RESET;
      rows_reg = ROWS_RESET;
      errors = 0;
      rows_checked = 0;
      loads_seen = 0;
      macs_seen = 0;
    endfunction

    static function int clamp_count(int v, int bound);
      if (v == 0) return 1;
      return (v > bound) ? bound : v;
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_COLS) cols_reg = data[COLS_CFG_W-1:0];
      else if (idx == CFG_ROWS) rows_reg = data[ROWS_CFG_W-1:0];
    endfunction

    function void note_item(cmv_op_t op, logic [COL_W-1:0] col,
                            logic signed [PART_W-1:0] a_re, logic signed [PART_W-1:0] a_im);
      logic signed [PART_W-1:0] x_re;
      logic signed [PART_W-1:0] x_im;
      longint                   p_re;
      longint                   p_im;
      int                       ncols;
      int                       nrows;
      row_result_t              r;
      if (op == OP_LOAD) begin
        vec_store[col] = {a_im, a_re};
        loads_seen++;
        return;
      end
      macs_seen++;
      x_re = vec_store[col][PART_W-1:0];
      x_im = vec_store[col][VEC_W-1:PART_W];
      p_re = longint'(a_re) * longint'(x_re) - longint'(a_im) * longint'(x_im);
      p_im = longint'(a_re) * longint'(x_im) + longint'(a_im) * longint'(x_re);
      acc_re = acc_re + p_re[ACC_W-1:0];
      acc_im = acc_im + p_im[ACC_W-1:0];
      ncols = clamp_count(int'(cols_reg), COL_BOUND);
      if (int'(col) != ncols - 1) return;
      nrows = clamp_count(int'(rows_reg), ROW_BOUND);
      r.re = acc_re;
      r.im = acc_im;
      r.row = row_ctr;
      r.fin = (int'(row_ctr) >= nrows - 1);
      pending_rows.push_back(r);
      acc_re = '0;
      acc_im = '0;
      row_ctr = r.fin ? '0 : row_ctr + 1'b1;
    endfunction

    task check_result(logic [ACC_W-1:0] re, logic [ACC_W-1:0] im,
                      logic [ROW_W-1:0] row, logic fin);
      row_result_t want;
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("row %0d delivered with nothing outstanding", row));
        return;
      end
      want = pending_rows.pop_front();
      rows_checked++;
      if (re !== want.re)
        report_mismatch($sformatf("row %0d product_re %h, want %h", want.row, re, want.re));
      if (im !== want.im)
        report_mismatch($sformatf("row %0d product_im %h, want %h", want.row, im, want.im));
      if (row !== want.row)
        report_mismatch($sformatf("row_number %0d, want %0d", row, want.row));
      if (fin !== want.fin)
        report_mismatch($sformatf("row %0d final_row %b, want %b", want.row, fin, want.fin));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cmv_item_if   items_ch ();
  cmv_result_if results_ch ();

  complex_matrix_vector_mac dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_ch),
    .results   (results_ch)
  );

  row_scoreboard sb = new();

  // idling knobs, percentages per cycle
  int send_idle_pct;
  int stall_pct;
  // receiver hold-off, counted down by the receiver process
  int hold_left;
  int phases_run;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: ready changes on the falling edge only
  always @(negedge clk) begin
    if (hold_left > 0) begin
      results_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      results_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor: a transfer is taken at the rising edge
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready)
      sb.check_result(results_ch.product_re, results_ch.product_im,
                      results_ch.row_number, results_ch.final_row);
  end

  // --------------------------------------------------------------------------
  // drivers and stimulus
  // --------------------------------------------------------------------------
  function automatic logic signed [PART_W-1:0] rand_part();
    // one in eight picks a corner value, the rest are uniform
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: return PART_MIN;
        1: return PART_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return PART_W'($urandom());
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(cmv_op_t op, logic [COL_W-1:0] col,
                           logic signed [PART_W-1:0] re, logic signed [PART_W-1:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid     <= 1'b1;
    items_ch.operation <= op;
    items_ch.col_index <= col;
    items_ch.value_re  <= re;
    items_ch.value_im  <= im;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    sb.note_item(op, col, re, im);
    @(negedge clk);
  endtask

  // register writes leave the write enable high so that writes can follow back to back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.configure(idx, data);
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering, wait for every outstanding row, then let the pipeline empty
  task automatic settle();
    int waited;
    waited = 0;
    items_ch.valid <= 1'b0;
    while (sb.pending_rows.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_rows.size() != 0) begin
      sb.report_mismatch($sformatf("%0d rows never delivered", sb.pending_rows.size()));
      sb.pending_rows.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 67; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 67; end
      default:       begin send_idle_pct = 9;  stall_pct = 9;  end
    endcase
  endtask

  // well-formed rows with random content, salted with stray loads,
  // repeated or early columns and dropped elements
  task automatic stream_rows(int n_rows, int ncols);
    for (int r = 0; r < n_rows; r++) begin
      for (int j = 0; j < ncols; j++) begin
        if ($urandom_range(99) < 8)
          send_item(OP_LOAD, COL_W'($urandom_range(VEC_DEPTH - 1)), rand_part(), rand_part());
        if (ncols > 1 && $urandom_range(99) < 4)
          send_item(OP_MAC, COL_W'($urandom_range(ncols - 2)), rand_part(), rand_part());
        if (j != ncols - 1 && $urandom_range(99) < 3) continue;
        send_item(OP_MAC, COL_W'(j), rand_part(), rand_part());
      end
    end
  endtask

  task automatic run_phase(int cols_data, int rows_data, idle_mode_t mode, int n_rows,
                           bit preload, int hold);
    int ncols;
    settle();
    set_idling(mode);
    write_reg(CFG_COLS, CFG_DATA_W'(cols_data));
    write_reg(CFG_ROWS, CFG_DATA_W'(rows_data));
    end_writes();
    ncols = row_scoreboard::clamp_count(cols_data % (2 ** COLS_CFG_W), COL_BOUND);
    // every column that a row reads is written first
    if (preload)
      for (int c = 0; c < ncols; c++) send_item(OP_LOAD, COL_W'(c), rand_part(), rand_part());
    hold_left = hold;
    stream_rows(n_rows, ncols);
    phases_run++;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_COLS;
    cfg_data = '0;
    items_ch.valid = 1'b0;
    items_ch.operation = OP_LOAD;
    items_ch.col_index = '0;
    items_ch.value_re = '0;
    items_ch.value_im = '0;
    results_ch.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    phases_run = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: three columns, two rows, spare register indexes written with junk
    write_reg(CFG_COLS, 3);
    write_reg(CFG_ROWS, 2);
    write_reg(CFG_IDX_SPARE_LO, '1);
    write_reg(CFG_IDX_SPARE_HI, '0);
    end_writes();

    // vector corners, plus the top and middle column of the store
    send_item(OP_LOAD, 0, PART_MAX, PART_MIN);
    send_item(OP_LOAD, 1, PART_MIN, PART_MIN);
    send_item(OP_LOAD, 2, PART_MIN, PART_MAX);
    send_item(OP_LOAD, COL_W'(VEC_DEPTH - 1), '1, 1);
    send_item(OP_LOAD, COL_W'(VEC_DEPTH / 2), PART_MAX, '1);

    // row 0 with the largest magnitudes
    send_item(OP_MAC, 0, PART_MIN, PART_MIN);
    send_item(OP_MAC, 1, PART_MIN, PART_MAX);
    send_item(OP_MAC, 2, PART_MAX, PART_MIN);

    // row 1: out of order, a column beyond the count, a reload mid-row and a repeat
    send_item(OP_MAC, 1, PART_MIN, PART_MIN);
    send_item(OP_MAC, COL_W'(VEC_DEPTH - 1), PART_MAX, PART_MAX);
    send_item(OP_LOAD, 0, '0, '0);
    send_item(OP_MAC, 0, PART_MAX, PART_MAX);
    send_item(OP_MAC, 1, PART_MIN, PART_MIN);
    send_item(OP_MAC, 2, '0, '0);

    // row counter wraps: the last column alone finishes row 0 again
    send_item(OP_MAC, 2, '1, 1);
    phases_run++;

    // zero counts act as one; long receiver hold-off so the queue fills
    run_phase(0, 0, IDLE_NONE, 40, 1'b0, 300);
    // one column, full row range, to advance the counter
    run_phase(1, ROW_BOUND, IDLE_SENDER, 30, 1'b0, 0);
    // fewer rows than the counter already stands at
    run_phase(4, 5, IDLE_RECEIVER, 12, 1'b1, 0);
    run_phase(17, 3, IDLE_BOTH, 8, 1'b1, 0);
    // counts above range clamp to the largest; whole store loaded
    run_phase(2 ** CFG_DATA_W - 1, 2 ** CFG_DATA_W - 1, IDLE_NONE, 1, 1'b1, 0);
    run_phase(COL_BOUND, ROW_BOUND, IDLE_SENDER, 1, 1'b0, 0);
    run_phase(2, 7, IDLE_RECEIVER, 40, 1'b0, 0);
    run_phase(5, 1, IDLE_BOTH, 15, 1'b0, 0);

    settle();

    $display("covered %0d transfers in (%0d vector loads, %0d matrix elements), %0d rows checked",
             sb.loads_seen + sb.macs_seen, sb.loads_seen, sb.macs_seen, sb.rows_checked);
    $display("over %0d settings incl. clamped counts, row counter restart and a long hold-off",
             phases_run);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
